[sv/sle_pkg.sv]
package sle_pkg;

	localparam int CNT_W          = 6;
	localparam int BYTE_W         = 8;
	localparam int LINE_DEPTH_DEF = 32;
	localparam logic [CNT_W-1:0] MAX_LEN_RST = 6'd32;

	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_LINE = 2'd1,
		KIND_END  = 2'd2,
		KIND_ESC  = 2'd3
	} kind_t;

	// one result beat
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic [CNT_W-1:0]  len;
		logic              last;
	} res_t;

	// line store access for one cycle
	typedef struct packed {
		logic              wr_en;
		logic [CNT_W-1:0]  wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic              rd_en;
		logic [CNT_W-1:0]  rd_addr;
	} mem_req_t;

endpackage

[sv/sle_line_mem.sv]
module sle_line_mem
	import sle_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF,
	parameter int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
	input  logic              clk,
	input  mem_req_t          req,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [LINE_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr[ADDR_W-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/sle_ctrl.sv]
module sle_ctrl
	import sle_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [CNT_W-1:0]  max_len,
	input  logic              slot_free,
	output logic              emit_valid,
	output res_t              res,
	output mem_req_t          mem_req,
	input  logic [BYTE_W-1:0] rd_data
);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ECHO = 4'b0010,
		S_LINE = 4'b0100,
		S_END  = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		M_ESC  = 2'd0,
		M_CHAR = 2'd1,
		M_BS   = 2'd2,
		M_CR   = 2'd3
	} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [1:0]        step_q;
	logic [BYTE_W-1:0] byte_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  idx_q;
	logic              esc_q;

	logic              accept;
	logic              fire;
	logic              room;
	logic              printable;
	logic [CNT_W-1:0]  idx_nx;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign emit_valid = (state_q != S_IDLE);
	assign fire      = emit_valid && slot_free;
	assign printable = (rx_byte >= CH_SPACE);
	assign room      = (fill_q < max_len) && (fill_q < DEPTH_CNT);
	assign idx_nx    = idx_q + CNT_W'(1);

	always_comb begin
		mem_req         = '0;
		mem_req.wr_en   = accept && !esc_q && printable && room;
		mem_req.wr_addr = fill_q;
		mem_req.wr_data = rx_byte;
		if (fire && (state_q == S_ECHO) && (mode_q == M_CR) && (step_q == 2'd1)
				&& (len_q != '0)) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = '0;
		end else if (fire && (state_q == S_LINE) && (idx_nx < len_q)) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = idx_nx;
		end
	end

	always_comb begin
		res      = '0;
		res.kind = KIND_ECHO;
		case (state_q)
			S_ECHO: begin
				case (mode_q)
					M_ESC: begin
						res.kind = KIND_ESC;
						res.data = byte_q;
						res.last = 1'b1;
					end
					M_CHAR: begin
						res.data = byte_q;
						res.last = 1'b1;
					end
					M_BS: begin
						res.data = (step_q == 2'd1) ? CH_SPACE : CH_BS;
						res.last = (step_q == 2'd2);
					end
					M_CR: begin
						res.data = (step_q == 2'd0) ? CH_CR : CH_LF;
					end
					default: res = '0;
				endcase
			end
			S_LINE: begin
				res.kind = KIND_LINE;
				res.data = rd_data;
			end
			S_END: begin
				res.kind = KIND_END;
				res.len  = len_q;
				res.last = 1'b1;
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			esc_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (esc_q) begin
							esc_q   <= 1'b0;
							fill_q  <= '0;
							state_q <= S_ECHO;
						end else if (rx_byte == CH_ESC) begin
							esc_q <= 1'b1;
						end else if (printable) begin
							if (room) begin
								fill_q  <= fill_q + CNT_W'(1);
								state_q <= S_ECHO;
							end
						end else if (rx_byte == CH_BS) begin
							if (fill_q != '0) begin
								fill_q  <= fill_q - CNT_W'(1);
								state_q <= S_ECHO;
							end
						end else if (rx_byte == CH_CR) begin
							fill_q  <= '0;
							state_q <= S_ECHO;
						end
					end
				end
				S_ECHO: begin
					if (fire) begin
						step_q <= step_q + 2'd1;
						case (mode_q)
							M_BS: begin
								if (step_q == 2'd2) state_q <= S_IDLE;
							end
							M_CR: begin
								if (step_q == 2'd1) begin
									state_q <= (len_q != '0) ? S_LINE : S_END;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LINE: begin
					if (fire && !(idx_nx < len_q)) begin
						state_q <= S_END;
					end
				end
				S_END: begin
					if (fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload of the current item
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= rx_byte;
			len_q  <= fill_q;
			if (esc_q) begin
				mode_q <= M_ESC;
			end else if (rx_byte == CH_BS) begin
				mode_q <= M_BS;
			end else if (rx_byte == CH_CR) begin
				mode_q <= M_CR;
			end else begin
				mode_q <= M_CHAR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ECHO) begin
			idx_q <= '0;
		end else if (fire && (state_q == S_LINE)) begin
			idx_q <= idx_nx;
		end
	end

endmodule

[sv/serial_line_editor.sv]
// Line editor with echo for bytes from a serial link. Each accepted rx_byte beat
// produces zero or more result beats: a printable byte (0x20 and up) is stored and
// echoed while the line holds fewer than min(max_len, LINE_DEPTH) bytes; backspace on
// a non-empty line echoes BS, space, BS and drops one byte; CR echoes CR and LF, plays
// back the stored line as line-byte beats, then a line-end beat with the length, and
// empties the line; ESC gives nothing but turns the next byte, whatever it is, into an
// escape beat that also empties the line. Other control bytes are dropped. The final
// beat of each item has last set. Timing: the block takes one byte at a time and holds
// in_stall high until every beat of that byte has been loaded into the output register,
// one beat per cycle while out_stall is low. Line playback reads the line memory one
// entry ahead, so its registered read adds no bubble. max_len is written through the
// cfg channel (always ready); the user must write it only while the block is idle, as
// the block itself does not enforce this. Reset sets max_len to 32. The line memory
// needs no clearing after reset.
module serial_line_editor
	import sle_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [BYTE_W-1:0] out_byte,
	output logic [CNT_W-1:0]  line_length,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data
);

	logic [CNT_W-1:0]  max_len_q;
	logic              out_valid_q;
	res_t              out_q;

	logic              slot_free;
	logic              emit_valid;
	res_t              res;
	mem_req_t          mem_req;
	logic [BYTE_W-1:0] rd_data;

	// configuration register: accept every write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// output register: refill as soon as the held beat is taken
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign out_byte    = out_q.data;
	assign line_length = out_q.len;
	assign last        = out_q.last;

	sle_ctrl #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.max_len    (max_len_q),
		.slot_free  (slot_free),
		.emit_valid (emit_valid),
		.res        (res),
		.mem_req    (mem_req),
		.rd_data    (rd_data)
	);

	sle_line_mem #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
	import sle_pkg::*;

	localparam int DEPTH        = LINE_DEPTH_DEF;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RAND_ITEMS   = 370;
	localparam int HOLD_CYCLES  = 500;

	// How a directed row is treated: a register write, a byte checked against the
	// predictor, a byte whose single beat is typed in, or a byte that yields nothing.
	typedef enum logic [1:0] {
		ROW_CFG   = 2'd0,
		ROW_PRED  = 2'd1,
		ROW_TYPED = 2'd2,
		ROW_QUIET = 2'd3
	} row_op_t;

	typedef struct packed {
		row_op_t           op;
		logic [BYTE_W-1:0] rx;    // byte to send, or max_len value on ROW_CFG
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic [CNT_W-1:0]  len;
	} row_t;

	localparam int DIR_N = 30;
	localparam row_t DIR_TAB [DIR_N] = '{
		// reset state: empty line, max_len 32
		'{ROW_PRED,  CH_CR,    KIND_ECHO, 8'h00,    6'd0},  // CR on an empty line
		'{ROW_QUIET, CH_BS,    KIND_ECHO, 8'h00,    6'd0},  // backspace on an empty line
		'{ROW_TYPED, CH_SPACE, KIND_ECHO, CH_SPACE, 6'd0},  // lowest printable
		'{ROW_TYPED, 8'hFF,    KIND_ECHO, 8'hFF,    6'd0},  // highest printable
		'{ROW_TYPED, 8'h7F,    KIND_ECHO, 8'h7F,    6'd0},  // DEL counts as printable
		'{ROW_QUIET, 8'h00,    KIND_ECHO, 8'h00,    6'd0},  // other control bytes
		'{ROW_QUIET, 8'h1F,    KIND_ECHO, 8'h00,    6'd0},
		'{ROW_QUIET, CH_LF,    KIND_ECHO, 8'h00,    6'd0},
		'{ROW_PRED,  CH_BS,    KIND_ECHO, 8'h00,    6'd0},  // erase sequence
		'{ROW_PRED,  CH_CR,    KIND_ECHO, 8'h00,    6'd0},  // play back two bytes
		// escape handling: the byte after ESC is reported whatever it is
		'{ROW_QUIET, CH_ESC,   KIND_ECHO, 8'h00,    6'd0},
		'{ROW_TYPED, CH_ESC,   KIND_ESC,  CH_ESC,   6'd0},
		'{ROW_TYPED, 8'h41,    KIND_ECHO, 8'h41,    6'd0},
		'{ROW_QUIET, CH_ESC,   KIND_ECHO, 8'h00,    6'd0},
		'{ROW_TYPED, CH_CR,    KIND_ESC,  CH_CR,    6'd0},  // also empties the line
		'{ROW_PRED,  CH_CR,    KIND_ECHO, 8'h00,    6'd0},
		'{ROW_QUIET, CH_ESC,   KIND_ECHO, 8'h00,    6'd0},
		'{ROW_TYPED, CH_BS,    KIND_ESC,  CH_BS,    6'd0},
		'{ROW_QUIET, CH_ESC,   KIND_ECHO, 8'h00,    6'd0},
		'{ROW_TYPED, 8'h00,    KIND_ESC,  8'h00,    6'd0},
		// one-byte line: second printable is dropped once full
		'{ROW_CFG,   8'd1,     KIND_ECHO, 8'h00,    6'd0},
		'{ROW_TYPED, 8'h61,    KIND_ECHO, 8'h61,    6'd0},
		'{ROW_QUIET, 8'h62,    KIND_ECHO, 8'h00,    6'd0},
		'{ROW_PRED,  CH_CR,    KIND_ECHO, 8'h00,    6'd0},
		// zero-length limit: nothing is ever stored
		'{ROW_CFG,   8'd0,     KIND_ECHO, 8'h00,    6'd0},
		'{ROW_QUIET, 8'h63,    KIND_ECHO, 8'h00,    6'd0},
		'{ROW_PRED,  CH_CR,    KIND_ECHO, 8'h00,    6'd0},
		// limit above the line depth clamps to the depth
		'{ROW_CFG,   8'd63,    KIND_ECHO, 8'h00,    6'd0},
		'{ROW_TYPED, 8'h7E,    KIND_ECHO, 8'h7E,    6'd0},
		'{ROW_PRED,  CH_CR,    KIND_ECHO, 8'h00,    6'd0}
	};

	localparam int ML_N = 7;
	localparam logic [CNT_W-1:0] ML_LIST [ML_N] = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd33, 6'd31, 6'd5};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        kind;
	logic [BYTE_W-1:0] out_byte;
	logic [CNT_W-1:0]  line_length;
	logic              last;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data;

	serial_line_editor #(
		.LINE_DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.out_byte   (out_byte),
		.line_length(line_length),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Shadow of the editor state, advanced on every accepted input beat.
	logic [BYTE_W-1:0] line_buf [DEPTH];
	int                fill_cnt;
	bit                esc_armed;
	logic [CNT_W-1:0]  max_len_r;

	res_t step_beats [$];  // beats caused by the byte just edited
	res_t beats_due  [$];  // beats still owed by the block, oldest first
	row_t sent_q     [$];  // rows offered on the input, not yet accepted

	int  fails;
	int  burst_left;
	int  items_counted;
	bit  hold_req;
	longint cycles;

	function automatic void add_beat(input kind_t k, input logic [BYTE_W-1:0] d,
			input logic [CNT_W-1:0] n);
		res_t b;
		b.kind = k;
		b.data = d;
		b.len  = n;
		b.last = 1'b0;
		step_beats.push_back(b);
	endfunction

	// Edit one received byte into the shadow line and list the beats it causes.
	function automatic void edit_rx_byte(input logic [BYTE_W-1:0] c);
		int lim;
		lim = (int'(max_len_r) < DEPTH) ? int'(max_len_r) : DEPTH;
		step_beats.delete();
		if (esc_armed) begin
			esc_armed = 1'b0;
			fill_cnt  = 0;
			add_beat(KIND_ESC, c, '0);
		end else if (c == CH_ESC) begin
			esc_armed = 1'b1;
		end else if (c >= CH_SPACE) begin
			if (fill_cnt < lim) begin
				line_buf[fill_cnt] = c;
				fill_cnt++;
				add_beat(KIND_ECHO, c, '0);
			end
		end else if (c == CH_BS) begin
			if (fill_cnt > 0) begin
				fill_cnt--;
				add_beat(KIND_ECHO, CH_BS, '0);
				add_beat(KIND_ECHO, CH_SPACE, '0);
				add_beat(KIND_ECHO, CH_BS, '0);
			end
		end else if (c == CH_CR) begin
			add_beat(KIND_ECHO, CH_CR, '0);
			add_beat(KIND_ECHO, CH_LF, '0);
			for (int i = 0; i < fill_cnt; i++)
				add_beat(KIND_LINE, line_buf[i], '0);
			add_beat(KIND_END, '0, CNT_W'(fill_cnt));
			fill_cnt = 0;
		end
		if (step_beats.size() > 0)
			step_beats[step_beats.size()-1].last = 1'b1;
	endfunction

	// Watch all three channels at the rising edge; values read here are the ones
	// that were stable before the edge.
	always @(posedge clk) begin : watch
		row_t r;
		res_t want;
		res_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				max_len_r = cfg_data;

			if (in_valid && !in_stall) begin
				r = sent_q.pop_front();
				edit_rx_byte(rx_byte);
				case (r.op)
					ROW_TYPED: begin
						want.kind = r.kind;
						want.data = r.data;
						want.len  = r.len;
						want.last = 1'b1;
						beats_due.push_back(want);
					end
					ROW_QUIET: begin
					end
					default: begin
						foreach (step_beats[i])
							beats_due.push_back(step_beats[i]);
					end
				endcase
			end

			if (out_valid && !out_stall) begin
				got.kind = kind_t'(kind);
				got.data = out_byte;
				got.len  = line_length;
				got.last = last;
				if (beats_due.size() == 0) begin
					$display("%0t: unexpected beat: kind %0d byte %02h len %0d last %0d",
						$time, got.kind, got.data, got.len, got.last);
					fails++;
				end else begin
					want = beats_due.pop_front();
					// fields in order: kind, byte, len, last
					if (got.kind != want.kind || got.data != want.data ||
							got.len != want.len || got.last != want.last) begin
						$display("%0t: expected %0d %02h %0d %0d, actual %0d %02h %0d %0d",
							$time, want.kind, want.data, want.len, want.last,
							got.kind, got.data, got.len, got.last);
						fails++;
					end
				end
			end
		end
	end

	// Receiver: stall in segments of random style, with a long hold-off on request.
	initial begin : receiver
		int seg;
		int mode;
		int hold_left;
		seg       = 0;
		mode      = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (seg == 0) begin
					seg  = $urandom_range(1, 80);
					mode = $urandom_range(0, 3);
				end
				seg--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= ($urandom_range(0, 99) < 75);
					default: out_stall <= seg[2];
				endcase
			end
		end
	end

	// Offer one byte; open a new burst after a random gap when the old one is used up.
	task automatic send_item(input row_t r);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(10, 40)) @(posedge clk);
			else
				repeat ($urandom_range(1, 4)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
		end
		sent_q.push_back(r);
		in_valid <= 1'b1;
		rx_byte  <= r.rx;
		do @(posedge clk); while (in_stall);
		burst_left--;
		items_counted++;
	endtask

	task automatic send_rx(input logic [BYTE_W-1:0] b);
		row_t r;
		r      = '0;
		r.op   = ROW_PRED;
		r.rx   = b;
		send_item(r);
	endtask

	// Drop valid and wait until every owed beat is out, then let a byte that
	// yields nothing finish inside the block.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (beats_due.size() != 0 || sent_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_max_len(input logic [CNT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : timeout
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb failed");
		$finish;
	end

	initial begin : stimulus
		int  r;
		int  k;
		int  lim;
		int  target;
		int  phase;
		bit  held;
		bit  paused;
		logic [CNT_W-1:0] mlv;

		in_valid      = 1'b0;
		rx_byte       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		fails         = 0;
		burst_left    = 0;
		items_counted = 0;
		hold_req      = 1'b0;
		fill_cnt      = 0;
		esc_armed     = 1'b0;
		max_len_r     = MAX_LEN_RST;
		held          = 1'b0;
		paused        = 1'b0;
		phase         = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_N; i++) begin
			if (DIR_TAB[i].op == ROW_CFG) begin
				settle_idle();
				write_max_len(DIR_TAB[i].rx[CNT_W-1:0]);
			end else begin
				send_item(DIR_TAB[i]);
			end
		end

		// random phases, each under its own limit
		items_counted = 0;
		while (items_counted < RAND_ITEMS) begin
			settle_idle();
			mlv = (phase < ML_N) ? ML_LIST[phase] : CNT_W'($urandom_range(0, 63));
			write_max_len(mlv);
			lim    = (int'(mlv) < DEPTH) ? int'(mlv) : DEPTH;
			target = items_counted + $urandom_range(40, 70);
			while (items_counted < target) begin
				// hold the receiver off while bytes keep coming, so the block backs up
				if (!held && items_counted >= 150) begin
					hold_req = 1'b1;
					held     = 1'b1;
				end
				// pause the sender until the block has drained
				if (!paused && items_counted >= 260) begin
					settle_idle();
					paused = 1'b1;
				end
				r = $urandom_range(0, 99);
				if (r < 60) begin
					// a line: mostly short, sometimes running past the limit
					k = ($urandom_range(0, 99) < 15) ? lim + $urandom_range(0, 3)
					                                 : $urandom_range(0, 6);
					for (int j = 0; j < k; j++) begin
						send_rx(BYTE_W'($urandom_range(32, 255)));
						if ($urandom_range(0, 99) < 12)
							send_rx(CH_BS);
					end
					if ($urandom_range(0, 9) != 0) begin
						send_rx(CH_CR);
					end else begin
						send_rx(CH_ESC);
						send_rx(BYTE_W'($urandom_range(0, 255)));
					end
				end else if (r < 75) begin
					send_rx(CH_ESC);
					send_rx(BYTE_W'($urandom_range(0, 255)));
				end else if (r < 85) begin
					repeat ($urandom_range(1, 3)) send_rx(CH_BS);
				end else if (r < 92) begin
					send_rx(BYTE_W'($urandom_range(0, 31)));
				end else begin
					send_rx(BYTE_W'($urandom_range(0, 255)));
				end
			end
			phase++;
		end

		settle_idle();
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
